>>> design/dlt_pkg.sv
// Shared types and constants for the line tokenizer: token and push records,
// token kinds, byte classes and the keyword table.
// No dependencies.
package dlt_pkg;

  localparam int KW_COUNT = 18;
  localparam int KW_TEXT_W = 88;   // up to 11 characters per keyword
  localparam logic [KW_COUNT-1:0] KW_ALL = '1;

  // Kind codes as they appear on the result channel
  localparam logic [2:0] K_COMMENT  = 3'd0;
  localparam logic [2:0] K_KEYWORD  = 3'd1;
  localparam logic [2:0] K_NORMAL   = 3'd2;
  localparam logic [2:0] K_STRING   = 3'd3;
  localparam logic [2:0] K_VARIABLE = 3'd4;
  localparam logic [2:0] K_NUMBER   = 3'd5;

  // Keywords, right-justified: the last character sits in bits [7:0]
  localparam logic [KW_TEXT_W-1:0] KW_TEXT [KW_COUNT] = '{
    KW_TEXT_W'("FROM"), KW_TEXT_W'("RUN"), KW_TEXT_W'("CMD"), KW_TEXT_W'("LABEL"),
    KW_TEXT_W'("MAINTAINER"), KW_TEXT_W'("EXPOSE"), KW_TEXT_W'("ENV"),
    KW_TEXT_W'("ADD"), KW_TEXT_W'("COPY"), KW_TEXT_W'("ENTRYPOINT"),
    KW_TEXT_W'("VOLUME"), KW_TEXT_W'("USER"), KW_TEXT_W'("WORKDIR"),
    KW_TEXT_W'("ARG"), KW_TEXT_W'("ONBUILD"), KW_TEXT_W'("STOPSIGNAL"),
    KW_TEXT_W'("HEALTHCHECK"), KW_TEXT_W'("SHELL")
  };

  localparam logic [3:0] KW_LEN [KW_COUNT] = '{
    4'd4, 4'd3, 4'd3, 4'd5, 4'd10, 4'd6, 4'd3, 4'd3, 4'd4,
    4'd10, 4'd6, 4'd4, 4'd7, 4'd3, 4'd7, 4'd10, 4'd11, 4'd5
  };

  typedef struct packed {
    logic        last;
    logic [2:0]  kind;
    logic [12:0] length;
    logic [11:0] start;
  } dlt_token_t;

  // Up to two tokens produced by one input item, in emission order
  typedef struct packed {
    logic [1:0] count;
    dlt_token_t tok1;
    dlt_token_t tok0;
  } dlt_push_t;

  function automatic logic is_upper(input logic [7:0] c);
    return (c >= 8'h41) && (c <= 8'h5A);
  endfunction

  function automatic logic is_alpha(input logic [7:0] c);
    return is_upper(c) || ((c >= 8'h61) && (c <= 8'h7A));
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

  function automatic logic is_alnum(input logic [7:0] c);
    return is_alpha(c) || is_digit(c);
  endfunction

endpackage

>>> design/dlt_keyword.sv
// Parallel keyword matcher: narrows the candidate set by one character and
// reports whether a word is a complete keyword. Uses dlt_pkg.
module dlt_keyword (
  input  logic [7:0]                   c,
  input  logic [dlt_pkg::KW_COUNT-1:0] cands_base,  // set before this character
  input  logic [3:0]                   wc_base,     // characters seen so far
  input  logic [dlt_pkg::KW_COUNT-1:0] cands_reg,   // stored word state
  input  logic [3:0]                   wc_reg,
  output logic [dlt_pkg::KW_COUNT-1:0] cands_upd,
  output logic [3:0]                   wc_upd,
  output logic                         kw_reg,      // stored word is a keyword
  output logic                         kw_upd       // updated word is a keyword
);
  import dlt_pkg::*;

  logic [3:0] idx [KW_COUNT];

  always_comb begin
    for (int k = 0; k < KW_COUNT; k++) begin
      idx[k] = KW_LEN[k] - 4'd1 - wc_base;
      cands_upd[k] = cands_base[k] && (wc_base < KW_LEN[k]) &&
                     (KW_TEXT[k][{idx[k], 3'b000} +: 8] == c);
    end
    wc_upd = (wc_base < 4'd15) ? wc_base + 4'd1 : wc_base;
  end

  always_comb begin
    kw_reg = 1'b0;
    kw_upd = 1'b0;
    for (int k = 0; k < KW_COUNT; k++) begin
      if (cands_reg[k] && (KW_LEN[k] == wc_reg)) kw_reg = 1'b1;
      if (cands_upd[k] && (KW_LEN[k] == wc_upd)) kw_upd = 1'b1;
    end
  end

endmodule

>>> design/dlt_scanner.sv
// Per-byte scanner: holds the line state and turns one accepted byte into
// up to two tokens. Uses dlt_pkg and dlt_keyword.
module dlt_scanner #(
  parameter int MAX_LINE_LENGTH = 4096
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              accept,
  input  logic [7:0]        c,
  input  logic              eol,
  output dlt_pkg::dlt_push_t push
);
  import dlt_pkg::*;

  localparam int PW = $clog2(MAX_LINE_LENGTH + 1);

  typedef enum logic [3:0] {
    M_LEAD, M_COMMENT, M_WORD, M_GENERAL, M_STRING,
    M_DOLLAR, M_BRACE, M_VARNAME, M_NUMBER
  } mode_t;

  mode_t              mode, mode_next;
  logic [PW-1:0]      line_pos, line_pos_next;
  logic [PW-1:0]      tok_begin, tok_begin_next;
  logic               quote_single, quote_single_next;
  logic               esc_pending, esc_pending_next;
  logic [KW_COUNT-1:0] cands, cands_next;
  logic [3:0]         wc, wc_next;

  logic [KW_COUNT-1:0] cands_base, cands_upd;
  logic [3:0]         wc_base, wc_upd;
  logic               kw_reg, kw_upd;

  // Candidate emissions in order: closing token, one-byte normal, line-end close
  logic               ea, eb, ec;
  dlt_token_t         ta, tb, tc;
  logic               in_range, start_gen, word_applied;
  logic [PW-1:0]      p, lp_after;
  logic [7:0]         quote_char;

  assign cands_base = (mode == M_LEAD) ? KW_ALL : cands;
  assign wc_base    = (mode == M_LEAD) ? 4'd0 : wc;

  dlt_keyword u_kw (
    .c          (c),
    .cands_base (cands_base),
    .wc_base    (wc_base),
    .cands_reg  (cands),
    .wc_reg     (wc),
    .cands_upd  (cands_upd),
    .wc_upd     (wc_upd),
    .kw_reg     (kw_reg),
    .kw_upd     (kw_upd)
  );

  always_comb begin
    mode_next         = mode;
    line_pos_next     = line_pos;
    tok_begin_next    = tok_begin;
    quote_single_next = quote_single;
    esc_pending_next  = esc_pending;
    cands_next        = cands;
    wc_next           = wc;
    ea = 1'b0; eb = 1'b0; ec = 1'b0;
    ta = '0; tb = '0; tc = '0;
    start_gen    = 1'b0;
    word_applied = 1'b0;
    p          = line_pos;
    in_range   = line_pos < PW'(MAX_LINE_LENGTH);
    lp_after   = in_range ? line_pos + PW'(1) : line_pos;
    quote_char = quote_single ? 8'h27 : 8'h22;

    if (in_range) begin
      unique case (mode)
        M_LEAD: begin
          if (c == 8'h20 || c == 8'h09) begin
            // blank before the first real byte: skipped
          end else if (c == 8'h23) begin
            mode_next      = M_COMMENT;
            tok_begin_next = p;
          end else if (is_upper(c) || c == 8'h5F) begin
            mode_next      = M_WORD;
            tok_begin_next = p;
            cands_next     = cands_upd;
            wc_next        = wc_upd;
            word_applied   = 1'b1;
          end else begin
            start_gen = 1'b1;
          end
        end
        M_COMMENT: ;
        M_WORD: begin
          if (is_alpha(c) || c == 8'h5F) begin
            cands_next   = cands_upd;
            wc_next      = wc_upd;
            word_applied = 1'b1;
          end else begin
            ea = 1'b1;
            ta.start  = 12'(tok_begin);
            ta.length = 13'(p - tok_begin);
            ta.kind   = kw_reg ? K_KEYWORD : K_NORMAL;
            start_gen = 1'b1;
          end
        end
        M_STRING: begin
          if (esc_pending) begin
            esc_pending_next = 1'b0;
          end else if (c == 8'h5C) begin
            esc_pending_next = !eol;
          end else if (c == quote_char) begin
            ea = 1'b1;
            ta.start  = 12'(tok_begin);
            ta.length = 13'(p + PW'(1) - tok_begin);
            ta.kind   = K_STRING;
            mode_next = M_GENERAL;
          end
        end
        M_DOLLAR: begin
          if (c == 8'h7B) begin
            mode_next = M_BRACE;
          end else if (is_alnum(c) || c == 8'h5F) begin
            mode_next = M_VARNAME;
          end else begin
            ea = 1'b1;
            ta.start  = 12'(tok_begin);
            ta.length = 13'(p - tok_begin);
            ta.kind   = K_VARIABLE;
            start_gen = 1'b1;
          end
        end
        M_BRACE: begin
          if (c == 8'h7D) begin
            ea = 1'b1;
            ta.start  = 12'(tok_begin);
            ta.length = 13'(p + PW'(1) - tok_begin);
            ta.kind   = K_VARIABLE;
            mode_next = M_GENERAL;
          end
        end
        M_VARNAME: begin
          if (!(is_alnum(c) || c == 8'h5F)) begin
            ea = 1'b1;
            ta.start  = 12'(tok_begin);
            ta.length = 13'(p - tok_begin);
            ta.kind   = K_VARIABLE;
            start_gen = 1'b1;
          end
        end
        M_NUMBER: begin
          if (!(is_alnum(c) || c == 8'h2E)) begin
            ea = 1'b1;
            ta.start  = 12'(tok_begin);
            ta.length = 13'(p - tok_begin);
            ta.kind   = K_NUMBER;
            start_gen = 1'b1;
          end
        end
        default: start_gen = 1'b1;   // general mode
      endcase

      // Byte opens a new token, or is a one-byte normal token
      if (start_gen) begin
        tok_begin_next = p;
        if (c == 8'h22 || c == 8'h27) begin
          mode_next         = M_STRING;
          quote_single_next = (c == 8'h27);
          esc_pending_next  = 1'b0;
        end else if (c == 8'h24) begin
          mode_next = M_DOLLAR;
        end else if (is_digit(c)) begin
          mode_next = M_NUMBER;
        end else begin
          eb = 1'b1;
          tb.start  = 12'(p);
          tb.length = 13'd1;
          tb.kind   = K_NORMAL;
          mode_next = M_GENERAL;
        end
      end
      line_pos_next = lp_after;
    end

    if (eol) begin
      // Open token closes at the end of the line
      tc.start  = 12'(tok_begin_next);
      tc.length = 13'(lp_after - tok_begin_next);
      tc.kind   = K_NORMAL;
      ec        = lp_after > tok_begin_next;
      unique case (mode_next)
        M_COMMENT: tc.kind = K_COMMENT;
        M_WORD: tc.kind = (word_applied ? kw_upd : kw_reg) ? K_KEYWORD : K_NORMAL;
        M_STRING: tc.kind = K_STRING;
        M_DOLLAR, M_BRACE, M_VARNAME: tc.kind = K_VARIABLE;
        M_NUMBER: tc.kind = K_NUMBER;
        default: ec = 1'b0;
      endcase
      mode_next         = M_LEAD;
      line_pos_next     = '0;
      tok_begin_next    = '0;
      quote_single_next = 1'b0;
      esc_pending_next  = 1'b0;
      cands_next        = KW_ALL;
      wc_next           = 4'd0;
    end
  end

  // Pack the first two emissions; last_of_run goes on the final one
  always_comb begin
    push.tok0 = ea ? ta : (eb ? tb : tc);
    push.tok1 = ea ? (eb ? tb : tc) : tc;
    push.count = 2'(ea) + 2'(eb) + 2'(ec);
    if (push.count == 2'd3) push.count = 2'd2;
    if (!accept) push.count = 2'd0;
    push.tok0.last = (push.count == 2'd1);
    push.tok1.last = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode         <= M_LEAD;
      line_pos     <= '0;
      tok_begin    <= '0;
      quote_single <= 1'b0;
      esc_pending  <= 1'b0;
      cands        <= KW_ALL;
      wc           <= 4'd0;
    end else if (accept) begin
      mode         <= mode_next;
      line_pos     <= line_pos_next;
      tok_begin    <= tok_begin_next;
      quote_single <= quote_single_next;
      esc_pending  <= esc_pending_next;
      cands        <= cands_next;
      wc           <= wc_next;
    end
  end

endmodule

>>> design/dlt_result_queue.sv
// Four-entry token queue: takes up to two tokens a cycle, hands out one.
// Uses dlt_pkg.
module dlt_result_queue (
  input  logic               clk,
  input  logic               rst,
  input  dlt_pkg::dlt_push_t push,
  input  logic               pop,
  output logic               room2,   // at least two free entries
  output logic               not_empty,
  output dlt_pkg::dlt_token_t head
);
  import dlt_pkg::*;

  dlt_token_t mem [4];
  logic [1:0] wr_ptr, rd_ptr;
  logic [2:0] count;

  assign room2     = count <= 3'd2;
  assign not_empty = count != 3'd0;
  assign head      = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push.count != 2'd0) mem[wr_ptr] <= push.tok0;
    if (push.count == 2'd2) mem[wr_ptr + 2'd1] <= push.tok1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 2'd0;
      rd_ptr <= 2'd0;
      count  <= 3'd0;
    end else begin
      wr_ptr <= wr_ptr + push.count;
      rd_ptr <= rd_ptr + 2'(pop);
      count  <= count + 3'(push.count) - 3'(pop);
    end
  end

endmodule

>>> design/dockerfile_line_tokenizer.sv
// Top level of the line tokenizer: byte stream in, highlighting tokens out.
// Depends on dlt_pkg, dlt_scanner, dlt_keyword and dlt_result_queue.
//
// Input channel (s_*): one byte of a text line per item, s_tlast on the
// final byte of the line. Output channel (m_*): one token per item, with
// start offset, length and kind; m_tlast marks the last token caused by a
// given input byte. An input byte may cause zero, one or two tokens.
//
// The tokens of an accepted byte are registered into the token queue and
// offered on m_tvalid. The scanner state updates at the accepting edge, so a
// new byte is taken every cycle while the token queue has room. Throughput:
// one byte per cycle while the queue has room; the output side drains one
// token a cycle while m_tready is high, so with a ready receiver only bytes
// that cause two tokens can slow the input side on average. The four-entry
// token queue sets this: s_tready is high while at least two entries are
// free, independent of s_tvalid. A stalled receiver fills the queue and
// then holds s_tready low; nothing is dropped. Reset (rst, synchronous)
// empties the queue and returns the scanner to the start-of-line state.
// Bytes beyond MAX_LINE_LENGTH within a line are accepted and ignored.
module dockerfile_line_tokenizer #(
  parameter int MAX_LINE_LENGTH = 4096
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // [7:0] char_byte
  input  logic        s_tlast,   // end_of_line
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,   // [11:0] token_start, [24:12] token_length,
                                 // [27:25] token_kind, [31:28] zero
  output logic        m_tlast    // last_of_run
);
  import dlt_pkg::*;

  dlt_push_t  push;
  dlt_token_t head;
  logic       accept, pop, room2, not_empty;

  assign s_tready = room2;
  assign accept   = s_tvalid && room2;
  assign pop      = m_tready && not_empty;

  dlt_scanner #(
    .MAX_LINE_LENGTH (MAX_LINE_LENGTH)
  ) u_scan (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .c      (s_tdata),
    .eol    (s_tlast),
    .push   (push)
  );

  dlt_result_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .pop       (pop),
    .room2     (room2),
    .not_empty (not_empty),
    .head      (head)
  );

  assign m_tvalid = not_empty;
  assign m_tdata  = {4'b0000, head.kind, head.length, head.start};
  assign m_tlast  = head.last;

endmodule
